### rtl/core/vna_pkg.sv
`timescale 1ns / 1ps
// vna_pkg: shared widths, opcodes and record types for the vertex normal averager
// depends on nothing; used by vertex_normal_averager, vna_front, vna_norm and vna_back
package vna_pkg;

   localparam int IDX_W = 16;   // widest vertex index the store can need
   localparam int TAG_W = 11;
   localparam int POS_W = 16;
   localparam int NRM_W = 16;
   localparam int SUM_W = 24;
   localparam int CNT_W = 8;
   localparam int VEC_W = 38;   // cross product components and sums as fed to the normalizer

   localparam logic [CNT_W-1:0]        COUNT_MAX = 8'd255;
   localparam logic signed [NRM_W-1:0] ONE_Q14   = 16'sd16384;
   localparam logic signed [SUM_W-1:0] SUM_MAX   = 24'sh7FFFFF;
   localparam logic signed [SUM_W-1:0] SUM_MIN   = 24'sh800000;

   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_TRIANGLE = 2'd1,
      OP_READ     = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [IDX_W-1:0]         idx_a;
      logic [IDX_W-1:0]         idx_b;
      logic [IDX_W-1:0]         idx_c;
      logic [TAG_W-1:0]         tag;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
   } cmd_type;

   typedef struct packed {
      logic signed [NRM_W-1:0]  normal_x;
      logic signed [NRM_W-1:0]  normal_y;
      logic signed [NRM_W-1:0]  normal_z;
      logic [TAG_W-1:0]         result_index;
      logic                     no_triangles;
   } rsp_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  pos_z;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_x;
   } pos_type;

   typedef struct packed {
      logic [CNT_W-1:0]         count;
      logic signed [SUM_W-1:0]  sum_z;
      logic signed [SUM_W-1:0]  sum_y;
      logic signed [SUM_W-1:0]  sum_x;
   } acc_type;

endpackage

### rtl/core/vertex_normal_averager.sv
`timescale 1ns / 1ps
// vertex_normal_averager: top level, smooth vertex normals from triangles
// depends on vna_pkg, vna_front and vna_back (and through them vna_fifo, vna_ram, vna_norm)
//
//   channel   handshake          payload
//   --------  -----------------  ------------------------------------------------------
//   request   req_push/req_full  opcode, vertex_index, pos_x/y/z, corner_a/b/c
//   response  rsp_pop/rsp_empty  normal_x/y/z (Q1.14), result_index, no_triangles
//
// requests are handled one at a time; most of the work of a read or a triangle is done
// in the serial normalizer, which shifts the magnitudes down, sums the squares, takes the
// square root and then divides each component
// after reset the accumulator store is zeroed one vertex per cycle, with req_full high
// meanwhile
// two-entry queues on both sides: requests are taken while a response waits to be popped
module vertex_normal_averager #(
   parameter int VERTEX_DEPTH = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   // request side
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [1:0]                       req_opcode,
   input  logic [vna_pkg::TAG_W-1:0]        req_vertex_index,
   input  logic signed [vna_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [vna_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [vna_pkg::POS_W-1:0] req_pos_z,
   input  logic [vna_pkg::TAG_W-1:0]        req_corner_a,
   input  logic [vna_pkg::TAG_W-1:0]        req_corner_b,
   input  logic [vna_pkg::TAG_W-1:0]        req_corner_c,
   // response side
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic signed [vna_pkg::NRM_W-1:0] rsp_normal_x,
   output logic signed [vna_pkg::NRM_W-1:0] rsp_normal_y,
   output logic signed [vna_pkg::NRM_W-1:0] rsp_normal_z,
   output logic [vna_pkg::TAG_W-1:0]        rsp_result_index,
   output logic                             rsp_no_triangles
);

   import vna_pkg::*;

   // front to back command queue
   logic    cmd_empty;
   logic    cmd_pop;
   cmd_type cmd;
   // back holds off requests while the store is being cleared
   logic    clear_busy;
   rsp_type rsp;

   // front: wraps indexes, drops the unused opcode, queues commands
   vna_front #(
      .VERTEX_DEPTH (VERTEX_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_vertex_index (req_vertex_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_corner_a     (req_corner_a),
      .req_corner_b     (req_corner_b),
      .req_corner_c     (req_corner_c),
      .clear_busy       (clear_busy),
      .cmd_pop          (cmd_pop),
      .cmd_empty        (cmd_empty),
      .cmd              (cmd)
   );

   // back: stores, cross product, normalizer, accumulate and read
   vna_back #(
      .VERTEX_DEPTH (VERTEX_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_empty  (cmd_empty),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .clear_busy (clear_busy),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp        (rsp)
   );

   // response fields straight from the head of the response queue
   assign rsp_normal_x     = rsp.normal_x;
   assign rsp_normal_y     = rsp.normal_y;
   assign rsp_normal_z     = rsp.normal_z;
   assign rsp_result_index = rsp.result_index;
   assign rsp_no_triangles = rsp.no_triangles;

endmodule

### rtl/core/vna_ram.sv
`timescale 1ns / 1ps
// vna_ram: generic single write port, single read port ram with registered read
// no dependencies
module vna_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/vna_fifo.sv
`timescale 1ns / 1ps
// vna_fifo: small register queue with push/full and pop/empty sides
// no dependencies
module vna_fifo #(
   parameter int WIDTH      = 8,
   parameter int DEPTH_LOG2 = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rdata
);

   localparam int ENTRIES = 1 << DEPTH_LOG2;

   logic [WIDTH-1:0]      slot_ff [ENTRIES];
   logic [DEPTH_LOG2:0]   wptr_ff, wptr_in;
   logic [DEPTH_LOG2:0]   rptr_ff, rptr_in;

   assign empty = (wptr_ff == rptr_ff);
   assign full  = (wptr_ff[DEPTH_LOG2] != rptr_ff[DEPTH_LOG2]) &&
                  (wptr_ff[DEPTH_LOG2-1:0] == rptr_ff[DEPTH_LOG2-1:0]);
   assign rdata = slot_ff[rptr_ff[DEPTH_LOG2-1:0]];

   assign wptr_in = (push && !full) ? wptr_ff + 1'b1 : wptr_ff;
   assign rptr_in = (pop && !empty) ? rptr_ff + 1'b1 : rptr_ff;

   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wptr_ff[DEPTH_LOG2-1:0]] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
   end

endmodule

### rtl/core/vna_front.sv
`timescale 1ns / 1ps
// vna_front: takes requests, wraps vertex indexes to the store depth, queues commands
// depends on vna_pkg and vna_fifo
module vna_front #(
   parameter int VERTEX_DEPTH = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_opcode,
   input  logic [vna_pkg::TAG_W-1:0]     req_vertex_index,
   input  logic signed [vna_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [vna_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [vna_pkg::POS_W-1:0] req_pos_z,
   input  logic [vna_pkg::TAG_W-1:0]     req_corner_a,
   input  logic [vna_pkg::TAG_W-1:0]     req_corner_b,
   input  logic [vna_pkg::TAG_W-1:0]     req_corner_c,
   input  logic                          clear_busy,
   input  logic                          cmd_pop,
   output logic                          cmd_empty,
   output vna_pkg::cmd_type              cmd
);

   import vna_pkg::*;

   localparam int CMD_W = $bits(cmd_type);

   logic             fifo_full;
   logic             push_cmd;
   cmd_type          cmd_in;
   logic [CMD_W-1:0] fifo_rdata;

   // index modulo depth by restoring subtraction, at most 255 wraps
   function automatic logic [IDX_W-1:0] wrap_index(input logic [TAG_W-1:0] v);
      logic [23:0] r;
      logic [23:0] lim;
      r = 24'(v);
      for (int k = 7; k >= 0; k--) begin
         lim = 24'(VERTEX_DEPTH) << k;
         if (r >= lim) begin
            r = r - lim;
         end
      end
      return r[IDX_W-1:0];
   endfunction

   assign req_full = fifo_full | clear_busy;
   assign push_cmd = req_push && !req_full && (op_type'(req_opcode) != OP_NONE);

   always_comb begin
      cmd_in.op    = op_type'(req_opcode);
      cmd_in.tag   = req_vertex_index;
      cmd_in.pos_x = req_pos_x;
      cmd_in.pos_y = req_pos_y;
      cmd_in.pos_z = req_pos_z;
      cmd_in.idx_b = wrap_index(req_corner_b);
      cmd_in.idx_c = wrap_index(req_corner_c);
      if (op_type'(req_opcode) == OP_TRIANGLE) begin
         cmd_in.idx_a = wrap_index(req_corner_a);
      end else begin
         cmd_in.idx_a = wrap_index(req_vertex_index);
      end
   end

   vna_fifo #(
      .WIDTH      (CMD_W),
      .DEPTH_LOG2 (1)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push_cmd),
      .full  (fifo_full),
      .wdata (cmd_in),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .rdata (fifo_rdata)
   );

   assign cmd = cmd_type'(fifo_rdata);

endmodule

### rtl/core/vna_norm.sv
`timescale 1ns / 1ps
// vna_norm: iterative normalizer of a signed 3-vector to Q1.14
// depends on vna_pkg
module vna_norm (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [vna_pkg::VEC_W-1:0] vec_x,
   input  logic signed [vna_pkg::VEC_W-1:0] vec_y,
   input  logic signed [vna_pkg::VEC_W-1:0] vec_z,
   output logic                             done,
   output logic signed [vna_pkg::NRM_W-1:0] norm_x,
   output logic signed [vna_pkg::NRM_W-1:0] norm_y,
   output logic signed [vna_pkg::NRM_W-1:0] norm_z
);

   import vna_pkg::*;

   typedef enum logic [2:0] {
      N_IDLE,
      N_SHIFT,
      N_SQUARE,
      N_ROOT,
      N_DIVLD,
      N_DIV,
      N_DONE
   } state_type;

   state_type               state_ff;
   logic [VEC_W-1:0]        mag_ff [3];
   logic                    neg_ff [3];
   logic [1:0]              sel_ff;
   logic                    phase_ff;
   logic [47:0]             prod_ff;
   logic [49:0]             sum_ff;
   logic [49:0]             rad_ff;
   logic [49:0]             root_ff;
   logic [49:0]             bit_ff;
   logic [24:0]             len_ff;
   logic [39:0]             num_ff;
   logic [14:0]             q_ff;
   logic [3:0]              step_ff;
   logic signed [NRM_W-1:0] nrm_ff [3];

   logic [49:0] sum_total;
   logic [49:0] trial;
   logic [49:0] root_next;
   logic [39:0] dvs;
   logic [14:0] q_next;
   logic [NRM_W-1:0] q_ext;
   logic        big;

   assign sum_total = sum_ff + 50'(prod_ff);
   assign trial     = root_ff + bit_ff;
   assign root_next = (rad_ff >= trial) ? (root_ff >> 1) + bit_ff : root_ff >> 1;
   assign dvs       = 40'(len_ff) << step_ff;
   assign q_next    = (num_ff >= dvs) ? q_ff | (15'd1 << step_ff) : q_ff;
   assign q_ext     = {1'b0, q_next};
   assign big       = (mag_ff[0][VEC_W-1:24] != '0) || (mag_ff[1][VEC_W-1:24] != '0) ||
                      (mag_ff[2][VEC_W-1:24] != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         unique case (state_ff)
            N_IDLE: begin
               if (start) begin
                  neg_ff[0] <= vec_x[VEC_W-1];
                  neg_ff[1] <= vec_y[VEC_W-1];
                  neg_ff[2] <= vec_z[VEC_W-1];
                  mag_ff[0] <= vec_x[VEC_W-1] ? -vec_x : vec_x;
                  mag_ff[1] <= vec_y[VEC_W-1] ? -vec_y : vec_y;
                  mag_ff[2] <= vec_z[VEC_W-1] ? -vec_z : vec_z;
                  state_ff  <= N_SHIFT;
               end
            end
            N_SHIFT: begin
               // bring all magnitudes below 2^24 together
               if (big) begin
                  mag_ff[0] <= mag_ff[0] >> 1;
                  mag_ff[1] <= mag_ff[1] >> 1;
                  mag_ff[2] <= mag_ff[2] >> 1;
               end else begin
                  sel_ff   <= 2'd0;
                  phase_ff <= 1'b0;
                  sum_ff   <= '0;
                  state_ff <= N_SQUARE;
               end
            end
            N_SQUARE: begin
               if (!phase_ff) begin
                  prod_ff  <= mag_ff[sel_ff][23:0] * mag_ff[sel_ff][23:0];
                  phase_ff <= 1'b1;
               end else begin
                  sum_ff   <= sum_total;
                  phase_ff <= 1'b0;
                  if (sel_ff == 2'd2) begin
                     if (sum_total == '0) begin
                        nrm_ff[0] <= '0;
                        nrm_ff[1] <= '0;
                        nrm_ff[2] <= '0;
                        state_ff  <= N_DONE;
                     end else begin
                        rad_ff   <= sum_total;
                        root_ff  <= '0;
                        bit_ff   <= 50'd1 << 48;
                        state_ff <= N_ROOT;
                     end
                  end else begin
                     sel_ff <= sel_ff + 2'd1;
                  end
               end
            end
            N_ROOT: begin
               // one result bit per trial from two radicand bits, one trial a cycle
               if (rad_ff >= trial) begin
                  rad_ff <= rad_ff - trial;
               end
               root_ff <= root_next;
               bit_ff  <= bit_ff >> 2;
               if (bit_ff == 50'd1) begin
                  len_ff   <= root_next[24:0];
                  sel_ff   <= 2'd0;
                  state_ff <= N_DIVLD;
               end
            end
            N_DIVLD: begin
               // rounded numerator m * 2^14 + len / 2
               num_ff   <= {2'b00, mag_ff[sel_ff][23:0], 14'd0} + 40'(len_ff >> 1);
               q_ff     <= '0;
               step_ff  <= 4'd14;
               state_ff <= N_DIV;
            end
            N_DIV: begin
               if (num_ff >= dvs) begin
                  num_ff <= num_ff - dvs;
               end
               q_ff    <= q_next;
               step_ff <= step_ff - 4'd1;
               if (step_ff == 4'd0) begin
                  nrm_ff[sel_ff] <= neg_ff[sel_ff] ? -q_ext : q_ext;
                  if (sel_ff == 2'd2) begin
                     state_ff <= N_DONE;
                  end else begin
                     sel_ff   <= sel_ff + 2'd1;
                     state_ff <= N_DIVLD;
                  end
               end
            end
            N_DONE: begin
               state_ff <= N_IDLE;
            end
            default: begin
               state_ff <= N_IDLE;
            end
         endcase
      end
   end

   assign done   = (state_ff == N_DONE);
   assign norm_x = nrm_ff[0];
   assign norm_y = nrm_ff[1];
   assign norm_z = nrm_ff[2];

endmodule

### rtl/core/vna_back.sv
`timescale 1ns / 1ps
// vna_back: command sequencer with position and accumulator stores and the result queue
// depends on vna_pkg, vna_ram, vna_norm and vna_fifo
module vna_back #(
   parameter int VERTEX_DEPTH = 2048
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   input  vna_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             clear_busy,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output vna_pkg::rsp_type rsp
);

   import vna_pkg::*;

   localparam int IW    = $clog2(VERTEX_DEPTH);
   localparam int POS_RW = $bits(pos_type);
   localparam int ACC_W = $bits(acc_type);
   localparam int RSP_W = $bits(rsp_type);

   typedef enum logic [3:0] {
      B_CLEAR,
      B_IDLE,
      B_LOAD,
      B_POS_RD,
      B_POS_CAP,
      B_DIFF,
      B_CROSS,
      B_FACE_NORM,
      B_FACE_WAIT,
      B_ACC_RD,
      B_ACC_WR,
      B_SUM_RD,
      B_SUM_EVAL,
      B_SUM_WAIT,
      B_OUT
   } state_type;

   state_type                state_ff;
   cmd_type                  cmd_ff;
   logic [1:0]               corner_ff;
   logic [IW-1:0]            clr_ff;
   logic signed [16:0]       p_ff  [3][3];
   logic signed [17:0]       d1_ff [3];
   logic signed [17:0]       d2_ff [3];
   logic [2:0]               step_ff;
   logic signed [35:0]       prod_ff;
   logic signed [VEC_W-1:0]  cr_ff [3];
   logic signed [NRM_W-1:0]  n_ff  [3];
   rsp_type                  rsp_ff;

   logic [IW-1:0]            corner_idx;
   logic [POS_RW-1:0]        pos_rdata;
   pos_type                  pos_rd;
   pos_type                  pos_wr;
   logic                     acc_we;
   logic [IW-1:0]            acc_waddr;
   acc_type                  acc_wdata;
   logic [ACC_W-1:0]         acc_rdata;
   acc_type                  acc_rd;
   acc_type                  acc_upd;
   logic signed [17:0]       mul_a;
   logic signed [17:0]       mul_b;
   logic [2:0]               step_m1;
   logic                     norm_start;
   logic                     norm_done;
   logic signed [VEC_W-1:0]  vec_x, vec_y, vec_z;
   logic signed [NRM_W-1:0]  norm_x, norm_y, norm_z;
   logic                     rsp_full;
   logic                     rsp_push;
   logic [RSP_W-1:0]         rsp_rdata;

   function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                       input logic signed [NRM_W-1:0] b);
      logic signed [SUM_W:0] s;
      s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
      if (s > (SUM_W+1)'(SUM_MAX)) begin
         return SUM_MAX;
      end else if (s < (SUM_W+1)'(SUM_MIN)) begin
         return SUM_MIN;
      end
      return s[SUM_W-1:0];
   endfunction

   always_comb begin
      unique case (corner_ff)
         2'd0:    corner_idx = cmd_ff.idx_a[IW-1:0];
         2'd1:    corner_idx = cmd_ff.idx_b[IW-1:0];
         default: corner_idx = cmd_ff.idx_c[IW-1:0];
      endcase
   end

   // position store
   always_comb begin
      pos_wr.pos_x = cmd_ff.pos_x;
      pos_wr.pos_y = cmd_ff.pos_y;
      pos_wr.pos_z = cmd_ff.pos_z;
   end

   vna_ram #(
      .WIDTH (POS_RW),
      .DEPTH (VERTEX_DEPTH)
   ) u_pos_ram (
      .clock (clock),
      .we    (state_ff == B_LOAD),
      .waddr (cmd_ff.idx_a[IW-1:0]),
      .wdata (pos_wr),
      .raddr (corner_idx),
      .rdata (pos_rdata)
   );

   assign pos_rd = pos_type'(pos_rdata);

   // accumulator store: sums and count of one vertex in one word
   assign acc_rd = acc_type'(acc_rdata);

   always_comb begin
      acc_upd.sum_x = sat_add(acc_rd.sum_x, -n_ff[1]);
      acc_upd.sum_y = sat_add(acc_rd.sum_y, n_ff[0]);
      acc_upd.sum_z = sat_add(acc_rd.sum_z, n_ff[2]);
      acc_upd.count = (acc_rd.count == COUNT_MAX) ? COUNT_MAX : acc_rd.count + 8'd1;
   end

   always_comb begin
      unique case (state_ff)
         B_CLEAR: begin
            acc_we    = 1'b1;
            acc_waddr = clr_ff;
            acc_wdata = '0;
         end
         B_LOAD: begin
            acc_we    = 1'b1;
            acc_waddr = cmd_ff.idx_a[IW-1:0];
            acc_wdata = '0;
         end
         B_ACC_WR: begin
            acc_we    = 1'b1;
            acc_waddr = corner_idx;
            acc_wdata = acc_upd;
         end
         default: begin
            acc_we    = 1'b0;
            acc_waddr = corner_idx;
            acc_wdata = acc_upd;
         end
      endcase
   end

   vna_ram #(
      .WIDTH (ACC_W),
      .DEPTH (VERTEX_DEPTH)
   ) u_acc_ram (
      .clock (clock),
      .we    (acc_we),
      .waddr (acc_waddr),
      .wdata (acc_wdata),
      .raddr (corner_idx),
      .rdata (acc_rdata)
   );

   // one shared multiplier for the six cross product terms
   always_comb begin
      unique case (step_ff)
         3'd0:    begin mul_a = d1_ff[1]; mul_b = d2_ff[2]; end
         3'd1:    begin mul_a = d1_ff[2]; mul_b = d2_ff[1]; end
         3'd2:    begin mul_a = d1_ff[2]; mul_b = d2_ff[0]; end
         3'd3:    begin mul_a = d1_ff[0]; mul_b = d2_ff[2]; end
         3'd4:    begin mul_a = d1_ff[0]; mul_b = d2_ff[1]; end
         default: begin mul_a = d1_ff[1]; mul_b = d2_ff[0]; end
      endcase
   end

   assign step_m1 = step_ff - 3'd1;

   // normalizer serves both the face normal and the final read
   assign norm_start = (state_ff == B_FACE_NORM) ||
                       ((state_ff == B_SUM_EVAL) && (acc_rd.count != '0));
   assign vec_x = (state_ff == B_SUM_EVAL) ? VEC_W'(acc_rd.sum_x) : cr_ff[0];
   assign vec_y = (state_ff == B_SUM_EVAL) ? VEC_W'(acc_rd.sum_y) : cr_ff[1];
   assign vec_z = (state_ff == B_SUM_EVAL) ? VEC_W'(acc_rd.sum_z) : cr_ff[2];

   vna_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (norm_start),
      .vec_x  (vec_x),
      .vec_y  (vec_y),
      .vec_z  (vec_z),
      .done   (norm_done),
      .norm_x (norm_x),
      .norm_y (norm_y),
      .norm_z (norm_z)
   );

   assign cmd_pop    = (state_ff == B_IDLE) && !cmd_empty;
   assign clear_busy = (state_ff == B_CLEAR);
   assign rsp_push   = (state_ff == B_OUT) && !rsp_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
      end else begin
         unique case (state_ff)
            B_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == IW'(VERTEX_DEPTH - 1)) begin
                  state_ff <= B_IDLE;
               end
            end
            B_IDLE: begin
               if (!cmd_empty) begin
                  cmd_ff    <= cmd;
                  corner_ff <= 2'd0;
                  unique case (cmd.op)
                     OP_LOAD:     state_ff <= B_LOAD;
                     OP_TRIANGLE: state_ff <= B_POS_RD;
                     OP_READ:     state_ff <= B_SUM_RD;
                     default:     state_ff <= B_IDLE;
                  endcase
               end
            end
            B_LOAD: begin
               state_ff <= B_IDLE;
            end
            B_POS_RD: begin
               state_ff <= B_POS_CAP;
            end
            B_POS_CAP: begin
               // rotate as (y, -x, z)
               p_ff[corner_ff][0] <= 17'(pos_rd.pos_y);
               p_ff[corner_ff][1] <= -17'(pos_rd.pos_x);
               p_ff[corner_ff][2] <= 17'(pos_rd.pos_z);
               if (corner_ff == 2'd2) begin
                  state_ff <= B_DIFF;
               end else begin
                  corner_ff <= corner_ff + 2'd1;
                  state_ff  <= B_POS_RD;
               end
            end
            B_DIFF: begin
               for (int j = 0; j < 3; j++) begin
                  d1_ff[j] <= 18'(p_ff[0][j]) - 18'(p_ff[1][j]);
                  d2_ff[j] <= 18'(p_ff[2][j]) - 18'(p_ff[1][j]);
               end
               step_ff  <= 3'd0;
               state_ff <= B_CROSS;
            end
            B_CROSS: begin
               if (step_ff != 3'd6) begin
                  prod_ff <= mul_a * mul_b;
               end
               if (step_ff != 3'd0) begin
                  if (!step_m1[0]) begin
                     cr_ff[step_m1[2:1]] <= VEC_W'(prod_ff);
                  end else begin
                     cr_ff[step_m1[2:1]] <= cr_ff[step_m1[2:1]] - VEC_W'(prod_ff);
                  end
               end
               if (step_ff == 3'd6) begin
                  state_ff <= B_FACE_NORM;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            B_FACE_NORM: begin
               state_ff <= B_FACE_WAIT;
            end
            B_FACE_WAIT: begin
               if (norm_done) begin
                  n_ff[0]   <= norm_x;
                  n_ff[1]   <= norm_y;
                  n_ff[2]   <= norm_z;
                  corner_ff <= 2'd0;
                  state_ff  <= B_ACC_RD;
               end
            end
            B_ACC_RD: begin
               state_ff <= B_ACC_WR;
            end
            B_ACC_WR: begin
               if (corner_ff == 2'd2) begin
                  state_ff <= B_IDLE;
               end else begin
                  corner_ff <= corner_ff + 2'd1;
                  state_ff  <= B_ACC_RD;
               end
            end
            B_SUM_RD: begin
               state_ff <= B_SUM_EVAL;
            end
            B_SUM_EVAL: begin
               rsp_ff.result_index <= cmd_ff.tag;
               if (acc_rd.count == '0) begin
                  rsp_ff.normal_x     <= '0;
                  rsp_ff.normal_y     <= '0;
                  rsp_ff.normal_z     <= ONE_Q14;
                  rsp_ff.no_triangles <= 1'b1;
                  state_ff            <= B_OUT;
               end else begin
                  rsp_ff.no_triangles <= 1'b0;
                  state_ff            <= B_SUM_WAIT;
               end
            end
            B_SUM_WAIT: begin
               if (norm_done) begin
                  rsp_ff.normal_x <= norm_x;
                  rsp_ff.normal_y <= norm_y;
                  rsp_ff.normal_z <= norm_z;
                  state_ff        <= B_OUT;
               end
            end
            B_OUT: begin
               if (!rsp_full) begin
                  state_ff <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   vna_fifo #(
      .WIDTH      (RSP_W),
      .DEPTH_LOG2 (1)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .full  (rsp_full),
      .wdata (rsp_ff),
      .pop   (rsp_pop),
      .empty (rsp_empty),
      .rdata (rsp_rdata)
   );

   assign rsp = rsp_type'(rsp_rdata);

endmodule

### verif/tb_vertex_normal_averager.sv
`timescale 1ns / 1ps
// tb_vertex_normal_averager: self-checking bench for the vertex normal averager
// depends on vna_pkg and vertex_normal_averager; holds its own normal predictor

module tb_vertex_normal_averager;
   import vna_pkg::*;

   // predicts read responses from loads and triangles, then checks them in order
   class normal_scoreboard;
      shortint     pos_x[2048], pos_y[2048], pos_z[2048];
      int          acc_x[2048], acc_y[2048], acc_z[2048];
      int unsigned hits[2048];
      rsp_type     expected_q[$];
      int          errors;

      function new();
         errors = 0;
         foreach (acc_x[i]) begin
            pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
            acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
            hits[i] = 0;
         end
      endfunction

      function longint unsigned int_sqrt(input longint unsigned x);
         longint unsigned r, b;
         r = 0;
         b = 64'h4000_0000_0000_0000;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function longint unsigned q14(input longint unsigned m, input longint unsigned len);
         return (m * 16384 + len / 2) / len;
      endfunction

      // scale to unit length in Q1.14, zero vector stays zero
      function void to_unit(input longint vx, vy, vz, output int nx, ny, nz);
         longint unsigned mx, my, mz, sq, len;
         mx = (vx < 0) ? -vx : vx;
         my = (vy < 0) ? -vy : vy;
         mz = (vz < 0) ? -vz : vz;
         while (mx >= 64'd16777216 || my >= 64'd16777216 || mz >= 64'd16777216) begin
            mx = mx >> 1; my = my >> 1; mz = mz >> 1;
         end
         sq = mx * mx + my * my + mz * mz;
         if (sq == 0) begin
            nx = 0; ny = 0; nz = 0;
            return;
         end
         len = int_sqrt(sq);
         nx = (vx < 0) ? -int'(q14(mx, len)) : int'(q14(mx, len));
         ny = (vy < 0) ? -int'(q14(my, len)) : int'(q14(my, len));
         nz = (vz < 0) ? -int'(q14(mz, len)) : int'(q14(mz, len));
      endfunction

      function int sat_sum(input int a, input int b);
         int s;
         s = a + b;
         if (s > 8388607) return 8388607;
         if (s < -8388608) return -8388608;
         return s;
      endfunction

      function void note(input op_type op, input logic [10:0] vi, input shortint x, y, z,
                         input logic [10:0] ca, cb, cc);
         int      k[3];
         longint  rx[3], ry[3], rz[3];
         longint  d1x, d1y, d1z, d2x, d2y, d2z;
         int      nx, ny, nz;
         rsp_type e;
         case (op)
            OP_LOAD: begin
               pos_x[vi] = x; pos_y[vi] = y; pos_z[vi] = z;
               acc_x[vi] = 0; acc_y[vi] = 0; acc_z[vi] = 0;
               hits[vi] = 0;
            end
            OP_TRIANGLE: begin
               k[0] = ca; k[1] = cb; k[2] = cc;
               for (int j = 0; j < 3; j++) begin
                  rx[j] = pos_y[k[j]];
                  ry[j] = -longint'(pos_x[k[j]]);
                  rz[j] = pos_z[k[j]];
               end
               d1x = rx[0] - rx[1]; d1y = ry[0] - ry[1]; d1z = rz[0] - rz[1];
               d2x = rx[2] - rx[1]; d2y = ry[2] - ry[1]; d2z = rz[2] - rz[1];
               to_unit(d1y * d2z - d1z * d2y, d1z * d2x - d1x * d2z,
                       d1x * d2y - d1y * d2x, nx, ny, nz);
               for (int j = 0; j < 3; j++) begin
                  acc_x[k[j]] = sat_sum(acc_x[k[j]], -ny);
                  acc_y[k[j]] = sat_sum(acc_y[k[j]], nx);
                  acc_z[k[j]] = sat_sum(acc_z[k[j]], nz);
                  if (hits[k[j]] < 255) hits[k[j]]++;
               end
            end
            OP_READ: begin
               e.result_index = vi;
               if (hits[vi] == 0) begin
                  e.normal_x = 0; e.normal_y = 0; e.normal_z = ONE_Q14;
                  e.no_triangles = 1'b1;
               end else begin
                  to_unit(acc_x[vi], acc_y[vi], acc_z[vi], nx, ny, nz);
                  e.normal_x = nx[15:0]; e.normal_y = ny[15:0]; e.normal_z = nz[15:0];
                  e.no_triangles = 1'b0;
               end
               expected_q.push_back(e);
            end
            default: ;
         endcase
      endfunction

      function void check(input rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $error("response for vertex %0d with no read outstanding", got.result_index);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (got.normal_x !== e.normal_x) begin
            $error("normal_x expected %0d got %0d", e.normal_x, got.normal_x); errors++;
         end
         if (got.normal_y !== e.normal_y) begin
            $error("normal_y expected %0d got %0d", e.normal_y, got.normal_y); errors++;
         end
         if (got.normal_z !== e.normal_z) begin
            $error("normal_z expected %0d got %0d", e.normal_z, got.normal_z); errors++;
         end
         if (got.result_index !== e.result_index) begin
            $error("result_index expected %0d got %0d", e.result_index, got.result_index);
            errors++;
         end
         if (got.no_triangles !== e.no_triangles) begin
            $error("no_triangles expected %0d got %0d", e.no_triangles, got.no_triangles);
            errors++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_push;
   logic                    req_full;
   logic [1:0]              req_opcode;
   logic [TAG_W-1:0]        req_vertex_index;
   logic signed [POS_W-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic [TAG_W-1:0]        req_corner_a, req_corner_b, req_corner_c;
   logic                    rsp_empty;
   logic                    rsp_pop;
   logic signed [NRM_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [TAG_W-1:0]        rsp_result_index;
   logic                    rsp_no_triangles;

   normal_scoreboard sb;
   bit               calm;      // no idling on either side while set
   int               pool[32];  // loaded vertices that triangles may use

   vertex_normal_averager i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_opcode       (req_opcode),
      .req_vertex_index (req_vertex_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_corner_a     (req_corner_a),
      .req_corner_b     (req_corner_b),
      .req_corner_c     (req_corner_c),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_result_index (rsp_result_index),
      .rsp_no_triangles (rsp_no_triangles)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function int gap_len();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 70);
   endfunction

   function shortint rand_pos();
      if ($urandom_range(0, 1)) return shortint'($urandom);
      return shortint'($urandom_range(0, 600)) - 16'sd300;
   endfunction

   // one request, held until it is taken at a rising edge
   task send(input op_type op, input logic [10:0] vi, input shortint x, y, z,
             input logic [10:0] ca, cb, cc);
      @(negedge clock);
      req_push         = 1'b1;
      req_opcode       = op;
      req_vertex_index = vi;
      req_pos_x        = x;
      req_pos_y        = y;
      req_pos_z        = z;
      req_corner_a     = ca;
      req_corner_b     = cb;
      req_corner_c     = cc;
      do @(posedge clock); while (req_full);
      sb.note(op, vi, x, y, z, ca, cb, cc);
   endtask

   task idle(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_push = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // request followed by a random pause; unused fields carry noise
   task issue(input op_type op, input logic [10:0] vi, input shortint x, y, z,
              input logic [10:0] ca, cb, cc);
      send(op, vi, x, y, z, ca, cb, cc);
      idle(gap_len());
   endtask

   task load(input logic [10:0] vi, input shortint x, y, z);
      issue(OP_LOAD, vi, x, y, z, 11'($urandom), 11'($urandom), 11'($urandom));
   endtask

   task triangle(input logic [10:0] ca, cb, cc);
      issue(OP_TRIANGLE, 11'($urandom), rand_pos(), rand_pos(), rand_pos(), ca, cb, cc);
   endtask

   task read(input logic [10:0] vi);
      issue(OP_READ, vi, rand_pos(), rand_pos(), rand_pos(),
            11'($urandom), 11'($urandom), 11'($urandom));
   endtask

   // stop sending until every outstanding read has answered
   task drain();
      @(negedge clock);
      req_push = 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task random_mix(input int n);
      int r, a, b, c;
      foreach (pool[i]) begin
         pool[i] = (i == 0) ? 0 : (i == 1) ? 2047 : $urandom_range(0, 2047);
         load(11'(pool[i]), rand_pos(), rand_pos(), rand_pos());
      end
      repeat (n) begin
         if ($urandom_range(0, 199) == 0) calm = ~calm;
         r = $urandom_range(0, 99);
         if (r < 10) begin
            // reload a pool entry, sometimes with a fresh vertex
            a = $urandom_range(0, 31);
            if ($urandom_range(0, 1)) pool[a] = $urandom_range(0, 2047);
            load(11'(pool[a]), rand_pos(), rand_pos(), rand_pos());
         end else if (r < 62) begin
            a = pool[$urandom_range(0, 31)];
            b = pool[$urandom_range(0, 31)];
            c = pool[$urandom_range(0, 31)];
            // a repeated corner now and then
            if ($urandom_range(0, 9) == 0) c = a;
            triangle(11'(a), 11'(b), 11'(c));
         end else if (r < 95) begin
            read(11'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
                                                 : pool[$urandom_range(0, 31)]));
         end else begin
            issue(OP_NONE, 11'($urandom), rand_pos(), rand_pos(), rand_pos(),
                  11'($urandom), 11'($urandom), 11'($urandom));
         end
      end
      calm = 1'b0;
   endtask

   // response side: pop with random stalls
   initial begin
      int stall;
      stall = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_pop = 1'b0;
            stall--;
         end else begin
            rsp_pop = 1'b1;
            stall = gap_len();
         end
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.normal_x     = rsp_normal_x;
         got.normal_y     = rsp_normal_y;
         got.normal_z     = rsp_normal_z;
         got.result_index = rsp_result_index;
         got.no_triangles = rsp_no_triangles;
         sb.check(got);
      end
   end

   initial begin
      int n;
      sb               = new();
      calm             = 1'b0;
      reset            = 1'b1;
      req_push         = 1'b0;
      req_opcode       = OP_NONE;
      req_vertex_index = '0;
      req_pos_x        = '0;
      req_pos_y        = '0;
      req_pos_z        = '0;
      req_corner_a     = '0;
      req_corner_b     = '0;
      req_corner_c     = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: position extremes, index extremes, flag and zero-sum reads
      load(0, -32768, -32768, -32768);
      load(2047, 32767, 32767, 32767);
      load(5, 0, 32767, -32768);
      read(0);                      // never counted, up vector with flag
      triangle(0, 2047, 5);
      read(0);
      read(2047);
      read(5);
      triangle(5, 5, 0);            // repeated corner, zero normal still counts
      load(9, 100, 0, 0);
      load(10, 100, 0, 0);
      load(11, 0, 0, 0);
      triangle(9, 10, 11);          // coincident corners, degenerate face
      read(9);                      // counted but zero sum
      load(12, 1, 2, 3);
      triangle(9, 11, 12);
      read(12);
      issue(OP_NONE, 3, 1, 1, 1, 0, 0, 0);
      read(1234);                   // never loaded
      load(0, 7, -7, 7);            // reload clears the sums
      read(0);
      triangle(2047, 5, 12);
      read(2047);
      drain();

      random_mix(650);
      drain();

      // saturation: one flat face hammered until count and z sum clip
      load(100, 1000, 0, 0);
      load(101, 0, 0, 0);
      load(102, 0, 1000, 0);
      for (n = 0; n < 540; n++) begin
         triangle(100, 101, 102);
         if (n % 30 == 0) read(101);
      end
      read(100);
      read(101);
      read(102);

      random_mix(80);

      drain();
      repeat (300) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
